>>> rtl/core/prefix_key_retry_sequencer_defines.svh
// Assertion macros shared by the sequencer RTL.
// Every check is clocked on clk and disabled while rst is high.
`ifndef PREFIX_KEY_RETRY_SEQUENCER_DEFINES_SVH
`define PREFIX_KEY_RETRY_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PKRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PKRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pkrs_pkg.sv
package pkrs_pkg;

  // Field widths.
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned ATT_W   = 4;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDAT_W  = 8;

  // Key code that stands for no key.
  localparam logic [KEY_W-1:0] KEY_NONE = 16'hFFFF;

  // Item modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_POLL  = 1'b1;

  // Event kinds.
  localparam logic [KIND_W-1:0] EV_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] EV_PRESS   = 2'd1;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

  // Sequencer phases; the fourth code is unused and acts as idle.
  localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HOLD   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_HOLD_POLL  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_LATCH_WAIT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_ATTEMPT    = 2'd2;

  // Configuration reset values.
  localparam logic [CNT_W-1:0] HOLD_POLL_RESET  = 8'd3;
  localparam logic [CNT_W-1:0] LATCH_WAIT_RESET = 8'd20;
  localparam logic [ATT_W-1:0] ATTEMPT_RESET    = 4'd3;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] first_key;
    logic [KEY_W-1:0] second_key;
    logic             latched;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [KEY_W-1:0]  event_key;
    logic              busy_res;
  } event_t;

  typedef struct packed {
    logic [CNT_W-1:0] hold_poll_count;
    logic [CNT_W-1:0] latch_wait_limit;
    logic [ATT_W-1:0] attempt_limit;
  } cfg_t;

endpackage

>>> rtl/core/pkrs_item_if.sv
interface pkrs_item_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [pkrs_pkg::KEY_W-1:0] first_key;
  logic [pkrs_pkg::KEY_W-1:0] second_key;
  logic                      latched;

  modport source (output valid, mode, first_key, second_key, latched, input ready);
  modport sink (input valid, mode, first_key, second_key, latched, output ready);
endinterface

>>> rtl/core/pkrs_event_if.sv
interface pkrs_event_if;
  logic                        valid;
  logic                        ready;
  logic [pkrs_pkg::KIND_W-1:0] event_kind;
  logic [pkrs_pkg::KEY_W-1:0]  event_key;
  logic                        busy_res;

  modport source (output valid, event_kind, event_key, busy_res, input ready);
  modport sink (input valid, event_kind, event_key, busy_res, output ready);
endinterface

>>> rtl/core/pkrs_cfg_if.sv
interface pkrs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pkrs_pkg::CIDX_W-1:0] index;
  logic [pkrs_pkg::CDAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/pkrs_cfg_regs.sv
module pkrs_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  pkrs_cfg_if.sink       cfg,
  output pkrs_pkg::cfg_t regs
);
  import pkrs_pkg::*;

  // Writes are always taken; an index past the register list is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.hold_poll_count  <= HOLD_POLL_RESET;
      regs.latch_wait_limit <= LATCH_WAIT_RESET;
      regs.attempt_limit    <= ATTEMPT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_HOLD_POLL:  regs.hold_poll_count  <= cfg.data;
        CFG_LATCH_WAIT: regs.latch_wait_limit <= cfg.data;
        CFG_ATTEMPT:    regs.attempt_limit    <= cfg.data[ATT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/pkrs_step.sv
`include "prefix_key_retry_sequencer_defines.svh"

module pkrs_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  pkrs_pkg::item_t item,
  input  pkrs_pkg::cfg_t  cfg_regs,
  output pkrs_pkg::event_t result
);
  import pkrs_pkg::*;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [CNT_W-1:0]   poll_counter, poll_counter_next;
  logic [ATT_W-1:0]   attempt_counter, attempt_counter_next;
  logic [KEY_W-1:0]   held_prefix, held_prefix_next;
  logic [KEY_W-1:0]   held_action, held_action_next;
  logic [KIND_W-1:0]  kind;
  logic [KEY_W-1:0]   key;
  logic               seq_active;

  assign seq_active = (phase == PH_HOLD) || (phase == PH_WAIT);

  // Next state and event for the item in the input register.
  always_comb begin
    phase_next           = phase;
    poll_counter_next    = poll_counter;
    attempt_counter_next = attempt_counter;
    held_prefix_next     = held_prefix;
    held_action_next     = held_action;
    kind                 = EV_NONE;
    key                  = KEY_NONE;
    if (item.mode == MODE_START) begin
      // A start is dropped while a sequence runs or when either key is missing.
      if (!seq_active && item.first_key != KEY_NONE && item.second_key != KEY_NONE) begin
        held_prefix_next     = item.first_key;
        held_action_next     = item.second_key;
        phase_next           = PH_HOLD;
        poll_counter_next    = '0;
        attempt_counter_next = ATT_W'(1);
        kind                 = EV_PRESS;
        key                  = item.first_key;
      end
    end else begin
      unique case (phase)
        PH_HOLD: begin
          priority if (poll_counter < cfg_regs.hold_poll_count) begin
            poll_counter_next = poll_counter + CNT_W'(1);
          end else begin
            poll_counter_next = '0;
            phase_next        = PH_WAIT;
            kind              = EV_RELEASE;
            key               = held_prefix;
          end
        end
        PH_WAIT: begin
          priority if (!item.latched && poll_counter < cfg_regs.latch_wait_limit) begin
            poll_counter_next = poll_counter + CNT_W'(1);
          end else if (!item.latched && attempt_counter < cfg_regs.attempt_limit) begin
            // Timed out: press the prefix again.
            attempt_counter_next = attempt_counter + ATT_W'(1);
            poll_counter_next    = '0;
            phase_next           = PH_HOLD;
            kind                 = EV_PRESS;
            key                  = held_prefix;
          end else begin
            phase_next = PH_IDLE;
            kind       = EV_PRESS;
            key        = held_action;
          end
        end
        PH_IDLE, PH_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign result.event_kind = kind;
  assign result.event_key  = key;
  assign result.busy_res   = (phase_next == PH_HOLD) || (phase_next == PH_WAIT);

  // State advances only when the item moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      poll_counter    <= '0;
      attempt_counter <= '0;
      held_prefix     <= KEY_NONE;
      held_action     <= KEY_NONE;
    end else if (go) begin
      phase           <= phase_next;
      poll_counter    <= poll_counter_next;
      attempt_counter <= attempt_counter_next;
      held_prefix     <= held_prefix_next;
      held_action     <= held_action_next;
    end
  end

  `PKRS_ASSERT_SAME(a_idle_poll_quiet, go && !seq_active && item.mode == MODE_POLL, kind == EV_NONE && !result.busy_res, "poll while idle produced an event")
  `PKRS_ASSERT_NEXT(a_busy_start_holds, go && seq_active && item.mode == MODE_START, $stable(phase) && $stable(held_prefix) && $stable(poll_counter), "start while busy changed the state")
  `PKRS_ASSERT_SAME(a_release_from_hold, kind == EV_RELEASE, phase == PH_HOLD && phase_next == PH_WAIT, "release outside the end of a hold")
  `PKRS_ASSERT_SAME(a_none_key, kind == EV_NONE, key == KEY_NONE, "no event must carry the empty key")

endmodule

>>> rtl/core/prefix_key_retry_sequencer.sv
// A transferred item waits in the input register until it can move into the result
// register, from which its result transfers.
// Throughput: one item per cycle while the result side does not stall.
// A stalled result holds off further input once the input register is also full.
// Reset (rst, synchronous, active high) empties both registers, puts the sequencer in idle
// with cleared counters and no held keys, and loads the configuration defaults.
`include "prefix_key_retry_sequencer_defines.svh"

module prefix_key_retry_sequencer (
  input  logic         clk,
  input  logic         rst,
  pkrs_item_if.sink    req,
  pkrs_event_if.source rsp,
  pkrs_cfg_if.sink     cfg
);
  import pkrs_pkg::*;

  cfg_t   cfg_regs;
  item_t  in_item;
  logic   in_vld;
  event_t step_result;
  event_t out_event;
  logic   out_vld;
  logic   advance;

  pkrs_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  // The item moves on when the result register is free or is draining.
  assign advance   = in_vld && (!out_vld || rsp.ready);
  assign req.ready = !in_vld || advance;

  pkrs_step u_step (
    .clk      (clk),
    .rst      (rst),
    .go       (advance),
    .item     (in_item),
    .cfg_regs (cfg_regs),
    .result   (step_result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.ready) begin
      in_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.mode       <= req.mode;
      in_item.first_key  <= req.first_key;
      in_item.second_key <= req.second_key;
      in_item.latched    <= req.latched;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event <= step_result;
    end
  end

  assign rsp.valid      = out_vld;
  assign rsp.event_kind = out_event.event_kind;
  assign rsp.event_key  = out_event.event_key;
  assign rsp.busy_res   = out_event.busy_res;

  `PKRS_ASSERT_NEXT(a_advance_fills, advance, out_vld, "result register empty after an item moved on")
  `PKRS_ASSERT_SAME(a_stall_cause, !req.ready, in_vld && out_vld && !rsp.ready, "input stalled without a full pipe")
  `PKRS_ASSERT_NEXT(a_drop_only_on_transfer, out_vld && !rsp.ready, out_vld, "result lost without a transfer")

endmodule

>>> bench/tb_prefix_key_retry_sequencer.sv
`timescale 1ns / 100ps

module tb_prefix_key_retry_sequencer;
  import pkrs_pkg::*;

  // Register index with no register behind it; writes to it change nothing.
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_STALL = 120;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    item_t             item;
    logic [CIDX_W-1:0] reg_idx;
    logic [CDAT_W-1:0] reg_val;
    logic              pinned;
    event_t            result;
  } script_row_t;

  typedef struct packed {
    logic   pinned;
    event_t result;
  } pin_entry_t;

  logic clk = 1'b0;
  logic rst;

  pkrs_item_if  item_bus ();
  pkrs_event_if event_bus ();
  pkrs_cfg_if   reg_bus ();

  prefix_key_retry_sequencer i_dut (
    .clk (clk),
    .rst (rst),
    .req (item_bus),
    .rsp (event_bus),
    .cfg (reg_bus)
  );

  always #10 clk = ~clk;

  // Predicted sequencer state and register copies.
  logic [PHASE_W-1:0] seq_phase;
  logic [CNT_W-1:0]   poll_count;
  logic [ATT_W-1:0]   try_count;
  logic [KEY_W-1:0]   held_first;
  logic [KEY_W-1:0]   held_second;
  logic [CNT_W-1:0]   hold_polls;
  logic [CNT_W-1:0]   latch_polls;
  logic [ATT_W-1:0]   max_tries;

  event_t      pending_events[$];
  pin_entry_t  pinned_events[$];
  script_row_t script[$];

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 7;
  int recv_idle_pct = 54;
  int stall_request = 0;

  // Advance the predicted sequencer by one item and return the event it causes.
  task automatic advance_sequencer(input item_t it, output event_t ev);
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    kind = EV_NONE;
    key = KEY_NONE;
    if (it.mode == MODE_START) begin
      if (seq_phase != PH_HOLD && seq_phase != PH_WAIT &&
          it.first_key != KEY_NONE && it.second_key != KEY_NONE) begin
        held_first = it.first_key;
        held_second = it.second_key;
        seq_phase = PH_HOLD;
        poll_count = '0;
        try_count = 4'd1;
        kind = EV_PRESS;
        key = it.first_key;
      end
    end else if (seq_phase == PH_HOLD) begin
      // The latch input plays no part while the prefix is held.
      if (poll_count < hold_polls) begin
        poll_count = poll_count + 1'b1;
      end else begin
        poll_count = '0;
        seq_phase = PH_WAIT;
        kind = EV_RELEASE;
        key = held_first;
      end
    end else if (seq_phase == PH_WAIT) begin
      if (!it.latched && poll_count < latch_polls) begin
        poll_count = poll_count + 1'b1;
      end else if (!it.latched && try_count < max_tries) begin
        try_count = try_count + 1'b1;
        poll_count = '0;
        seq_phase = PH_HOLD;
        kind = EV_PRESS;
        key = held_first;
      end else begin
        seq_phase = PH_IDLE;
        kind = EV_PRESS;
        key = held_second;
      end
    end
    ev.event_kind = kind;
    ev.event_key = key;
    ev.busy_res = (seq_phase == PH_HOLD || seq_phase == PH_WAIT);
  endtask

  // Compare one result transfer with the oldest expected event.
  task automatic check_event(input event_t got);
    event_t want;
    if (pending_events.size() == 0) begin
      $display("%0t: event with nothing expected: kind %0d key %h busy %0b",
               $time, got.event_kind, got.event_key, got.busy_res);
      mismatches++;
    end else begin
      want = pending_events.pop_front();
      if (got.event_kind !== want.event_kind) begin
        $display("%0t: event_kind expected %0d actual %0d",
                 $time, want.event_kind, got.event_kind);
        mismatches++;
      end
      if (got.event_key !== want.event_key) begin
        $display("%0t: event_key expected %h actual %h", $time, want.event_key, got.event_key);
        mismatches++;
      end
      if (got.busy_res !== want.busy_res) begin
        $display("%0t: busy_res expected %0b actual %0b", $time, want.busy_res, got.busy_res);
        mismatches++;
      end
    end
  endtask

  // Watch all three channels. Results are checked before new items are
  // predicted, so a stray result can never match an item of the same edge.
  always @(posedge clk) begin : monitor
    event_t     got;
    event_t     predicted;
    pin_entry_t pin;
    if (rst) begin
      seq_phase = PH_IDLE;
      poll_count = '0;
      try_count = '0;
      held_first = KEY_NONE;
      held_second = KEY_NONE;
      hold_polls = HOLD_POLL_RESET;
      latch_polls = LATCH_WAIT_RESET;
      max_tries = ATTEMPT_RESET;
    end else begin
      if (event_bus.valid && event_bus.ready) begin
        got.event_kind = event_bus.event_kind;
        got.event_key = event_bus.event_key;
        got.busy_res = event_bus.busy_res;
        check_event(got);
        results_seen++;
      end
      if (item_bus.valid && item_bus.ready) begin
        advance_sequencer({item_bus.mode, item_bus.first_key, item_bus.second_key,
                           item_bus.latched}, predicted);
        pin = pinned_events.pop_front();
        pending_events.push_back(pin.pinned ? pin.result : predicted);
      end
      if (reg_bus.valid && reg_bus.ready) begin
        case (reg_bus.index)
          CFG_HOLD_POLL:  hold_polls = reg_bus.data;
          CFG_LATCH_WAIT: latch_polls = reg_bus.data;
          CFG_ATTEMPT:    max_tries = reg_bus.data[ATT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    event_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        stall_left = stall_request;
        stall_request = 0;
      end
      if (stall_left != 0) begin
        stall_left--;
        event_bus.ready <= 1'b0;
      end else begin
        event_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // Offer one item, with random gaps in front, and wait for its transfer.
  task automatic offer_item(input item_t it, input logic pin, input event_t pin_ev);
    pin_entry_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.mode <= it.mode;
    item_bus.first_key <= it.first_key;
    item_bus.second_key <= it.second_key;
    item_bus.latched <= it.latched;
    entry.pinned = pin;
    entry.result = pin_ev;
    pinned_events.push_back(entry);
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    items_sent++;
  endtask

  // Write a register once every result in flight has come back. The channel
  // is then left idle before anything else is driven.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
    item_bus.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= idx;
    reg_bus.data <= val;
    @(posedge clk);
    while (!reg_bus.ready) @(posedge clk);
    reg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_item(input logic mode, input logic [KEY_W-1:0] k1,
                                   input logic [KEY_W-1:0] k2, input logic lat,
                                   input logic pin, input logic [KIND_W-1:0] kind,
                                   input logic [KEY_W-1:0] key, input logic busy);
    script_row_t row;
    row.kind = ROW_ITEM;
    row.item = {mode, k1, k2, lat};
    row.reg_idx = CFG_HOLD_POLL;
    row.reg_val = '0;
    row.pinned = pin;
    row.result = {kind, key, busy};
    script.push_back(row);
  endfunction

  function automatic void add_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
    script_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    script.push_back(row);
  endfunction

  // Directed rows. Results are typed in for idle polls and for the
  // starts at reset settings; the rest come from the predictor.
  function automatic void build_script();
    // Reset settings: poll while idle, starts with the no-key code, a good start, busy start.
    add_item(MODE_POLL,  16'h0000, 16'h0000, 1'b1, 1'b1, EV_NONE,  KEY_NONE, 1'b0);
    add_item(MODE_START, KEY_NONE, 16'h0000, 1'b0, 1'b1, EV_NONE,  KEY_NONE, 1'b0);
    add_item(MODE_START, 16'h0000, KEY_NONE, 1'b1, 1'b1, EV_NONE,  KEY_NONE, 1'b0);
    add_item(MODE_START, 16'h0000, 16'hFFFE, 1'b0, 1'b1, EV_PRESS, 16'h0000, 1'b1);
    add_item(MODE_START, 16'h1234, 16'h5678, 1'b0, 1'b1, EV_NONE,  KEY_NONE, 1'b1);
    // Latch reports during hold are ignored; release on the fourth poll.
    add_item(MODE_POLL,  KEY_NONE, KEY_NONE, 1'b1, 1'b0, EV_NONE,  KEY_NONE, 1'b0);
    add_item(MODE_POLL,  KEY_NONE, KEY_NONE, 1'b1, 1'b0, EV_NONE,  KEY_NONE, 1'b0);
    add_item(MODE_POLL,  KEY_NONE, KEY_NONE, 1'b1, 1'b0, EV_NONE,  KEY_NONE, 1'b0);
    add_item(MODE_POLL,  16'h0000, 16'h0000, 1'b0, 1'b0, EV_NONE,  KEY_NONE, 1'b0);
    add_item(MODE_POLL,  16'h0000, 16'h0000, 1'b1, 1'b0, EV_NONE,  KEY_NONE, 1'b0);
    add_item(MODE_POLL,  16'h0000, 16'h0000, 1'b0, 1'b1, EV_NONE,  KEY_NONE, 1'b0);
    // Zero limits end each phase at once; an attempt limit of zero means one try.
    add_reg(CFG_HOLD_POLL, 8'd0);
    add_reg(CFG_LATCH_WAIT, 8'd0);
    add_reg(CFG_ATTEMPT, 8'd0);
    add_reg(CFG_UNUSED, 8'hFF);
    add_item(MODE_START, 16'hABCD, 16'h1357, 1'b0, 1'b0, EV_NONE, KEY_NONE, 1'b0);
    add_item(MODE_POLL,  16'h0000, 16'h0000, 1'b0, 1'b0, EV_NONE, KEY_NONE, 1'b0);
    add_item(MODE_POLL,  16'h0000, 16'h0000, 1'b0, 1'b0, EV_NONE, KEY_NONE, 1'b0);
    // Two attempts, with the upper data bits set; one retry, then give up.
    add_reg(CFG_ATTEMPT, 8'hF2);
    add_item(MODE_START, 16'hFFFE, 16'h8000, 1'b0, 1'b0, EV_NONE, KEY_NONE, 1'b0);
    add_item(MODE_POLL,  16'h0000, 16'h0000, 1'b0, 1'b0, EV_NONE, KEY_NONE, 1'b0);
    add_item(MODE_POLL,  16'h0000, 16'h0000, 1'b0, 1'b0, EV_NONE, KEY_NONE, 1'b0);
    add_item(MODE_POLL,  16'h0000, 16'h0000, 1'b1, 1'b0, EV_NONE, KEY_NONE, 1'b0);
    add_item(MODE_POLL,  16'h0000, 16'h0000, 1'b0, 1'b0, EV_NONE, KEY_NONE, 1'b0);
    // Latch seen on the first wait poll.
    add_item(MODE_START, 16'h7FFF, 16'h0001, 1'b1, 1'b0, EV_NONE, KEY_NONE, 1'b0);
    add_item(MODE_POLL,  16'h0000, 16'h0000, 1'b0, 1'b0, EV_NONE, KEY_NONE, 1'b0);
    add_item(MODE_POLL,  16'h0000, 16'h0000, 1'b1, 1'b0, EV_NONE, KEY_NONE, 1'b0);
  endfunction

  // Mostly polls, which drive sequences forward, with some starts; a few
  // starts carry the no-key code.
  function automatic item_t random_item(input int latch_pct);
    item_t it;
    int    pick;
    it.first_key = KEY_W'($urandom);
    it.second_key = KEY_W'($urandom);
    if ($urandom_range(99) < 15) begin
      it.mode = MODE_START;
      it.latched = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 8) it.first_key = KEY_NONE;
      else if (pick < 16) it.second_key = KEY_NONE;
      else if (pick < 19) begin
        it.first_key = KEY_NONE;
        it.second_key = KEY_NONE;
      end
    end else begin
      it.mode = MODE_POLL;
      it.latched = ($urandom_range(99) < latch_pct);
    end
    return it;
  endfunction

  // One random phase: load the registers, optionally start a receiver
  // hold-off, then send the given number of items.
  task automatic run_batch(input logic [CNT_W-1:0] hold, input logic [CNT_W-1:0] limit,
                           input logic [CDAT_W-1:0] tries, input int latch_pct,
                           input int goal, input int stall);
    int first_count;
    write_reg(CFG_HOLD_POLL, hold);
    write_reg(CFG_LATCH_WAIT, limit);
    write_reg(CFG_ATTEMPT, tries);
    stall_request = stall;
    first_count = items_sent;
    while (items_sent - first_count < goal) offer_item(random_item(latch_pct), 1'b0, '0);
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    item_bus.valid <= 1'b0;
    item_bus.mode <= MODE_START;
    item_bus.first_key <= KEY_NONE;
    item_bus.second_key <= KEY_NONE;
    item_bus.latched <= 1'b0;
    reg_bus.valid <= 1'b0;
    reg_bus.index <= CFG_HOLD_POLL;
    reg_bus.data <= '0;
    build_script();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        offer_item(script[i].item, script[i].pinned, script[i].result);
      end
    end

    // Sender rarely idles, receiver often stalls.
    run_batch(8'd3, 8'd20, 8'd3, 5, 300, 0);
    run_batch(8'd0, 8'd0, 8'd1, 50, 250, 0);
    // Roles swapped.
    send_idle_pct = 54;
    recv_idle_pct = 7;
    run_batch(8'd1, 8'd2, 8'd15, 10, 300, 0);
    run_batch(8'd255, 8'd0, 8'd1, 50, 250, 0);
    // No idling at all; the long hold-off lets the block fill and stall its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_batch(8'd0, 8'd255, 8'd2, 1, 250, LONG_STALL);
    run_batch(8'd7, 8'd5, 8'd4, 20, 250, 0);

    item_bus.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_events.size() != 0) begin
      $display("%0t: %0d expected events never arrived", $time, pending_events.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
